// ===== design/ids_pkg.sv =====
package ids_pkg;

  localparam int OUT_SIZE          = 28;
  localparam int MAX_SOURCE_WIDTH  = 512;
  localparam int MAX_SOURCE_HEIGHT = 4095;
  localparam int MAX_RESULTS       = 4;

  localparam int W_WIDTH   = 10;
  localparam int H_WIDTH   = 12;
  localparam int CFG_W     = 12;
  localparam int RATIO_W   = 24;
  localparam int ROW_ACC_W = 29;
  localparam int COL_ACC_W = 25;
  localparam int COORD_W   = 5;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;
  localparam int CNT_W      = 4;

  localparam int BANK_DEPTH = 16;
  localparam int BANK_AW    = 4;

  // floor(2^29 / 7); (size << 16) / 28 == (size << 14) / 7
  localparam logic [26:0] RECIP7 = 27'd76695844;
  localparam int RECIP_SHIFT     = 29;

  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_EMIT_ENABLE   = 2'd2
  } cfg_index_t;

  localparam logic [W_WIDTH-1:0] RESET_SOURCE_WIDTH  = 10'd320;
  localparam logic [H_WIDTH-1:0] RESET_SOURCE_HEIGHT = 12'd240;

  typedef struct packed {
    logic                last;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [7:0]          value;
  } result_t;

  typedef struct packed {
    logic [2:0]    count;
    result_t [3:0] item;
  } push_t;

endpackage

// ===== design/ids_ratio.sv =====
module ids_ratio (
  input  logic                         clk,
  input  logic [ids_pkg::H_WIDTH-1:0]  size,
  output logic [ids_pkg::RATIO_W-1:0]  ratio
);

  logic [25:0] num;
  logic [25:0] num_d;
  logic [52:0] prod;
  logic [ids_pkg::RATIO_W-1:0] q0;
  logic [26:0] rem;

  assign num = {size, 14'b0};

  always_ff @(posedge clk) begin
    prod  <= 53'(num) * 53'(ids_pkg::RECIP7);
    num_d <= num;
  end

  // estimate is the quotient or one below it
  assign q0  = prod[52:ids_pkg::RECIP_SHIFT];
  assign rem = 27'(num_d) - (27'({q0, 3'b0}) - 27'(q0));

  always_ff @(posedge clk) begin
    ratio <= q0 + ids_pkg::RATIO_W'(rem >= 27'd7);
  end

endmodule

// ===== design/ids_out_fifo.sv =====
module ids_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  ids_pkg::push_t              push,
  input  logic                        pop,
  output logic [ids_pkg::CNT_W-1:0]   count,
  output ids_pkg::result_t            head
);

  ids_pkg::result_t entries [ids_pkg::FIFO_DEPTH];
  logic [ids_pkg::PTR_W-1:0] wptr;
  logic [ids_pkg::PTR_W-1:0] rptr;

  always_ff @(posedge clk) begin
    for (int k = 0; k < ids_pkg::MAX_RESULTS; k++) begin
      if (3'(k) < push.count) begin
        entries[wptr + ids_pkg::PTR_W'(k)] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + ids_pkg::PTR_W'(push.count);
      rptr  <= rptr + ids_pkg::PTR_W'(pop);
      count <= count + ids_pkg::CNT_W'(push.count) - ids_pkg::CNT_W'(pop);
    end
  end

  assign head = entries[rptr];

endmodule

// ===== design/image_downscale_to_28.sv =====
// A result passes the stage 2 registers and the output queue before it is offered.
// Throughput: one pixel per cycle; a pixel makes up to four results, which
// leave one per cycle while the receiver is ready, through an eight-entry
// queue; input stalls while the queue and the results one stage behind it
// hold more than four. Reset clears counters and queue; after reset or any
// register write, input waits while the ratio multiplier settles. Store is not cleared.
module image_downscale_to_28 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
  input  logic        s_axis_tuser,   // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_value, [12:8] out_row, [17:13] out_col
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int W  = ids_pkg::W_WIDTH;
  localparam int H  = ids_pkg::H_WIDTH;
  localparam int RW = ids_pkg::RATIO_W;
  localparam int RA = ids_pkg::ROW_ACC_W;
  localparam int CA = ids_pkg::COL_ACC_W;
  localparam int CW = ids_pkg::COORD_W;
  localparam int AW = ids_pkg::BANK_AW;
  localparam logic [CW-1:0] OUTN = CW'(ids_pkg::OUT_SIZE);

  // configuration
  logic [W-1:0] source_width;
  logic [H-1:0] source_height;
  logic         emit_enable;
  logic [1:0]   settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= ids_pkg::RESET_SOURCE_WIDTH;
      source_height <= ids_pkg::RESET_SOURCE_HEIGHT;
      emit_enable   <= 1'b1;
      settle        <= ids_pkg::SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle <= ids_pkg::SETTLE_CYCLES;
      unique case (cfg_index)
        ids_pkg::CFG_SOURCE_WIDTH:  source_width  <= cfg_data[W-1:0];
        ids_pkg::CFG_SOURCE_HEIGHT: source_height <= cfg_data[H-1:0];
        ids_pkg::CFG_EMIT_ENABLE:   emit_enable   <= cfg_data[0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  logic [W-1:0] w;
  logic [H-1:0] h;
  logic [RW-1:0] xr;
  logic [RW-1:0] yr;

  always_comb begin
    if (source_width < W'(ids_pkg::OUT_SIZE)) w = W'(ids_pkg::OUT_SIZE);
    else if (source_width > W'(ids_pkg::MAX_SOURCE_WIDTH)) w = W'(ids_pkg::MAX_SOURCE_WIDTH);
    else w = source_width;
    if (source_height < H'(ids_pkg::OUT_SIZE)) h = H'(ids_pkg::OUT_SIZE);
    else h = source_height;
  end

  ids_ratio u_ratio_x (.clk(clk), .size(H'(w)), .ratio(xr));
  ids_ratio u_ratio_y (.clk(clk), .size(h), .ratio(yr));

  // position state
  logic [H-1:0]  row_cnt;
  logic [8:0]    col_cnt;
  logic [RA-1:0] row_acc;
  logic [CA-1:0] col_acc;
  logic [CW-1:0] next_row;
  logic [CW-1:0] next_col;
  logic [7:0]    held;

  // queue and stage 2
  logic [ids_pkg::CNT_W-1:0] q_count;
  ids_pkg::result_t          q_head;
  ids_pkg::push_t            push;
  logic                      s2_valid;
  logic [2:0]                s2_n;
  logic                      accept;

  assign s_axis_tready = (settle == 2'd0) &&
    ((5'(q_count) + 5'(s2_valid ? s2_n : 3'd0)) <= 5'(ids_pkg::MAX_RESULTS));
  assign accept = s_axis_tvalid && s_axis_tready;

  // stage 1 decisions
  logic          fs;
  logic [7:0]    pix;
  logic [H-1:0]  r;
  logic [8:0]    c;
  logic [RA-1:0] racc;
  logic [CA-1:0] cacc;
  logic [CW-1:0] nr;
  logic [CW-1:0] nc;
  logic [12:0]   yi;
  logic [29:0]   racc_n;
  logic          has_bot, has_top, top_store, top_direct, last_row, row_end;
  logic [CW-1:0] t;
  logic [8:0]    x0, x1;
  logic [CA-1:0] cacc1, cacc2;
  logic [CW-1:0] j1;
  logic          ok0, ok1, edge0, edge1;
  logic [7:0]    a0, a1;
  logic          bot_e, dir_e;
  logic [2:0]    s1_n;
  logic [1:0]    adv;
  logic [RA-1:0] racc_adv;

  always_comb begin
    fs   = s_axis_tuser;
    pix  = s_axis_tdata;
    r    = fs ? '0 : row_cnt;
    c    = fs ? '0 : col_cnt;
    racc = fs ? '0 : row_acc;
    cacc = fs ? '0 : col_acc;
    nr   = fs ? '0 : next_row;
    nc   = fs ? '0 : next_col;

    yi      = racc[RA-1:16];
    racc_n  = 30'(racc) + 30'(yr);
    has_bot = (nr < OUTN) && ({1'b0, r} == yi + 13'd1);
    if (nr >= OUTN) has_top = 1'b0;
    else if (has_bot) has_top = ((nr + 5'd1) < OUTN) && (racc_n[29:16] == 14'(r));
    else has_top = ({1'b0, r} == yi);
    t          = has_bot ? nr + 5'd1 : nr;
    last_row   = (13'(r) + 13'd1) >= 13'(h);
    top_store  = has_top && !last_row;
    top_direct = has_top && last_row;
    row_end    = (10'(c) + 10'd1) >= w;

    x0    = cacc[CA-1:16];
    ok0   = (nc < OUTN) &&
            ((10'(c) == 10'(x0) + 10'd1) || ((c == x0) && row_end));
    edge0 = !(10'(c) == 10'(x0) + 10'd1);
    cacc1 = CA'(cacc + CA'(xr));
    cacc2 = CA'(cacc1 + CA'(xr));
    j1    = nc + 5'd1;
    x1    = cacc1[CA-1:16];
    ok1   = ok0 && (j1 < OUTN) &&
            ((10'(c) == 10'(x1) + 10'd1) || ((c == x1) && row_end));
    edge1 = !(10'(c) == 10'(x1) + 10'd1);
    a0    = edge0 ? pix : held;
    a1    = edge1 ? pix : held;

    bot_e = has_bot && emit_enable;
    dir_e = top_direct && emit_enable;
    s1_n  = (ok0 ? 3'(bot_e) + 3'(dir_e) : 3'd0) + (ok1 ? 3'(bot_e) + 3'(dir_e) : 3'd0);

    adv      = 2'(has_bot) + 2'(top_direct);
    racc_adv = RA'(racc + (adv == 2'd2 ? RA'({yr, 1'b0}) :
                           adv == 2'd1 ? RA'(yr) : RA'(0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      row_acc  <= '0;
      col_acc  <= '0;
      next_row <= '0;
      next_col <= '0;
      held     <= '0;
    end else if (accept) begin
      held <= pix;
      if (row_end) begin
        col_cnt  <= '0;
        next_col <= '0;
        col_acc  <= '0;
        if (last_row) begin
          row_cnt  <= '0;
          next_row <= '0;
          row_acc  <= '0;
        end else begin
          row_cnt  <= r + 12'd1;
          next_row <= nr + 5'(adv);
          row_acc  <= racc_adv;
        end
      end else begin
        col_cnt  <= c + 9'd1;
        next_col <= nc + 5'(ok0) + 5'(ok1);
        col_acc  <= ok1 ? cacc2 : (ok0 ? cacc1 : cacc);
        row_cnt  <= r;
        next_row <= nr;
        row_acc  <= racc;
      end
    end
  end

  // top pair store, split by column parity
  logic [15:0]   bank_even [ids_pkg::BANK_DEPTH];
  logic [15:0]   bank_odd  [ids_pkg::BANK_DEPTH];
  logic [15:0]   rd_even, rd_odd;
  logic [AW-1:0] ra_even, ra_odd, wa_even, wa_odd;
  logic [15:0]   wd_even, wd_odd;
  logic          we_even, we_odd;
  logic [5:0]    even_sum;

  always_comb begin
    even_sum = 6'(nc) + 6'(nc[0]);
    ra_even  = even_sum[AW:1];
    ra_odd   = nc[AW:1];
    we_even  = accept && top_store && ((ok0 && !nc[0]) || (ok1 && !j1[0]));
    we_odd   = accept && top_store && ((ok0 && nc[0]) || (ok1 && j1[0]));
    if (!nc[0]) begin
      wa_even = nc[AW:1];
      wd_even = {a0, pix};
      wa_odd  = j1[AW:1];
      wd_odd  = {a1, pix};
    end else begin
      wa_odd  = nc[AW:1];
      wd_odd  = {a0, pix};
      wa_even = j1[AW:1];
      wd_even = {a1, pix};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_even <= bank_even[ra_even];
      rd_odd  <= bank_odd[ra_odd];
    end
    if (we_even) bank_even[wa_even] <= wd_even;
    if (we_odd)  bank_odd[wa_odd]   <= wd_odd;
  end

  // stage 2
  logic [7:0]    s2_pix, s2_prev;
  logic          s2_bot_e, s2_dir_e;
  logic [1:0]    s2_ok, s2_edge;
  logic [CW-1:0] s2_j0, s2_j1, s2_row, s2_t;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_pix   <= pix;
      s2_prev  <= held;
      s2_bot_e <= bot_e;
      s2_dir_e <= dir_e;
      s2_ok    <= {ok1, ok0};
      s2_edge  <= {edge1, edge0};
      s2_j0    <= nc;
      s2_j1    <= j1;
      s2_row   <= nr;
      s2_t     <= t;
      s2_n     <= s1_n;
    end
  end

  ids_pkg::result_t slot [ids_pkg::MAX_RESULTS];
  logic [3:0]       slot_v;
  logic [15:0]      pair [2];
  logic [9:0]       bot_sum [2];
  logic [9:0]       dir_sum [2];
  logic [7:0]       pa [2];
  logic [CW-1:0]    pj [2];
  logic [2:0]       idx;

  always_comb begin
    pj[0] = s2_j0;
    pj[1] = s2_j1;
    for (int p = 0; p < 2; p++) begin
      pair[p] = pj[p][0] ? rd_odd : rd_even;
      if (s2_edge[p]) begin
        bot_sum[p] = 10'(pair[p][15:8]) + 10'(pair[p][15:8]) + 10'(pair[p][15:8]) +
                     10'(s2_pix);
      end else begin
        bot_sum[p] = 10'(pair[p][15:8]) + 10'(pair[p][7:0]) + 10'(s2_prev) + 10'(s2_pix);
      end
      pa[p]      = s2_edge[p] ? s2_pix : s2_prev;
      dir_sum[p] = 10'(pa[p]) + 10'(pa[p]) + 10'(pa[p]) + 10'(s2_pix);

      slot[2*p]       = '{last: 1'b0, col: pj[p], row: s2_row, value: bot_sum[p][9:2]};
      slot[2*p + 1]   = '{last: 1'b0, col: pj[p], row: s2_t, value: dir_sum[p][9:2]};
      slot_v[2*p]     = s2_valid && s2_ok[p] && s2_bot_e;
      slot_v[2*p + 1] = s2_valid && s2_ok[p] && s2_dir_e;
    end

    push = '0;
    idx  = 3'd0;
    for (int k = 0; k < ids_pkg::MAX_RESULTS; k++) begin
      if (slot_v[k]) begin
        push.item[idx[1:0]] = slot[k];
        idx = idx + 3'd1;
      end
    end
    push.count = idx;
    if (idx != 3'd0) push.item[2'(idx - 3'd1)].last = 1'b1;
  end

  ids_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_axis_tvalid && m_axis_tready),
    .count (q_count),
    .head  (q_head)
  );

  assign m_axis_tvalid = (q_count != '0);
  assign m_axis_tdata  = {6'b0, q_head.col, q_head.row, q_head.value};
  assign m_axis_tlast  = q_head.last;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] value;
    logic       start;
    logic       drain;
  } pix_item_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] pixel_value
  logic                s_axis_tuser = 1'b0;    // frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;           // [7:0] out_value, [12:8] out_row, [17:13] out_col
  logic                m_axis_tlast;
  logic                cfg_we = 1'b0;
  ids_pkg::cfg_index_t cfg_index = ids_pkg::CFG_SOURCE_WIDTH;
  logic [11:0]         cfg_data = 12'h000;

  image_downscale_to_28 uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pix_item_t        pix_q[$];
  ids_pkg::result_t avg_expected[$];

  // shadow of the block: registers and scan position
  logic [ids_pkg::W_WIDTH-1:0] cw_reg;
  logic [ids_pkg::H_WIDTH-1:0] ch_reg;
  logic                        emit_on;
  logic [15:0]                 top_pairs [ids_pkg::OUT_SIZE];
  logic [7:0]                  last_pix;
  logic [31:0]                 src_row, src_col, row_acc, col_acc, out_r, out_c;

  int  cycle_cnt = 0;
  int  mismatch_cnt = 0;
  int  sent_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_asks = 0;
  int  hold_done = 0;
  logic pix_taken = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] lo,
                                             input logic [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one source pixel: advance the scan and queue the averages it completes
  task automatic downscale_pixel(input logic [7:0] pix, input logic fs);
    logic [31:0] w, h, xr, yr, r, c, yi, x, a, b, j, sa, sb, v, t, adv;
    logic has_bot, has_top, top_store, top_direct, at_edge;
    ids_pkg::result_t res;
    ids_pkg::result_t step_res[$];
    w = clamp_size(32'(cw_reg), ids_pkg::OUT_SIZE, ids_pkg::MAX_SOURCE_WIDTH);
    h = clamp_size(32'(ch_reg), ids_pkg::OUT_SIZE, ids_pkg::MAX_SOURCE_HEIGHT);
    xr = (w << 16) / ids_pkg::OUT_SIZE;
    yr = (h << 16) / ids_pkg::OUT_SIZE;
    has_bot = 1'b0;
    has_top = 1'b0;
    top_store = 1'b0;
    top_direct = 1'b0;
    t = 0;
    if (fs) begin
      src_row = 0;
      src_col = 0;
      row_acc = 0;
      col_acc = 0;
      out_r = 0;
      out_c = 0;
    end
    r = src_row;
    c = src_col;
    if (out_r < ids_pkg::OUT_SIZE) begin
      yi = row_acc >> 16;
      if (r == yi + 1) begin
        has_bot = 1'b1;
        if (out_r + 1 < ids_pkg::OUT_SIZE && ((row_acc + yr) >> 16) == r) begin
          has_top = 1'b1;
          t = out_r + 1;
        end
      end else if (r == yi) begin
        has_top = 1'b1;
        t = out_r;
      end
    end
    if (has_top) begin
      if (r + 1 < h) top_store = 1'b1;
      else top_direct = 1'b1;
    end
    for (int p = 0; p < 2; p++) begin
      if (out_c >= ids_pkg::OUT_SIZE) break;
      x = col_acc >> 16;
      if (c == x + 1) begin
        a = 32'(last_pix);
        b = 32'(pix);
        at_edge = 1'b0;
      end else if (c == x && c + 1 >= w) begin
        a = 32'(pix);
        b = 32'(pix);
        at_edge = 1'b1;
      end else begin
        break;
      end
      j = out_c;
      if (has_bot) begin
        sa = 32'(top_pairs[j][15:8]);
        sb = 32'(top_pairs[j][7:0]);
        v = at_edge ? ((sa + sa + 32'(pix) + sa) >> 2)
                    : ((sa + sb + 32'(last_pix) + 32'(pix)) >> 2);
        if (emit_on) begin
          res.value = v[7:0];
          res.row = out_r[ids_pkg::COORD_W-1:0];
          res.col = j[ids_pkg::COORD_W-1:0];
          res.last = 1'b0;
          step_res.push_back(res);
        end
      end
      if (top_direct && emit_on) begin
        v = (a + b + a + a) >> 2;
        res.value = v[7:0];
        res.row = t[ids_pkg::COORD_W-1:0];
        res.col = j[ids_pkg::COORD_W-1:0];
        res.last = 1'b0;
        step_res.push_back(res);
      end
      if (top_store) top_pairs[j] = {a[7:0], b[7:0]};
      out_c = j + 1;
      col_acc = (col_acc + xr) & 32'h01FF_FFFF;
    end
    if (c + 1 >= w) begin
      src_col = 0;
      out_c = 0;
      col_acc = 0;
      adv = 32'(has_bot) + 32'(top_direct);
      out_r = out_r + adv;
      row_acc = (row_acc + adv * yr) & 32'h1FFF_FFFF;
      if (r + 1 >= h) begin
        src_row = 0;
        out_r = 0;
        row_acc = 0;
      end else begin
        src_row = r + 1;
      end
    end else begin
      src_col = c + 1;
    end
    last_pix = pix;
    for (int k = 0; k < step_res.size(); k++) begin
      res = step_res[k];
      res.last = (k == step_res.size() - 1);
      avg_expected.push_back(res);
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 200)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // monitor and shadow update
  always @(posedge clk) begin
    ids_pkg::result_t want;
    if (rst) begin
      pix_taken <= 1'b0;
      cw_reg = ids_pkg::RESET_SOURCE_WIDTH;
      ch_reg = ids_pkg::RESET_SOURCE_HEIGHT;
      emit_on = 1'b1;
      last_pix = 8'h00;
      src_row = 0;
      src_col = 0;
      row_acc = 0;
      col_acc = 0;
      out_r = 0;
      out_c = 0;
    end else begin
      pix_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (avg_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 200)
            $display("%0t: unexpected transaction: expected none, actual data %h last %b",
                     $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = avg_expected.pop_front();
          check_field("out_value", want.value, m_axis_tdata[7:0]);
          check_field("out_row", 8'(want.row), 8'(m_axis_tdata[12:8]));
          check_field("out_col", 8'(want.col), 8'(m_axis_tdata[17:13]));
          check_field("run_last", 8'(want.last), 8'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) downscale_pixel(s_axis_tdata, s_axis_tuser);
      if (cfg_we) begin
        case (cfg_index)
          ids_pkg::CFG_SOURCE_WIDTH:  cw_reg = cfg_data[ids_pkg::W_WIDTH-1:0];
          ids_pkg::CFG_SOURCE_HEIGHT: ch_reg = cfg_data[ids_pkg::H_WIDTH-1:0];
          ids_pkg::CFG_EMIT_ENABLE:   emit_on = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    pix_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pix_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pix_q.size() != 0 && !(pix_q[0].drain && avg_expected.size() != 0)) begin
        nxt = pix_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.value;
        s_axis_tuser <= nxt.start;
        gap_left = ((sent_cnt % 512) < 96) ? 0 : idle_len();
        sent_cnt++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = ((cycle_cnt % 700) < 120) ? 0 : idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(input ids_pkg::cfg_index_t idx, input logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(input logic [11:0] w, input logic [11:0] h, input logic emit);
    cfg_write(ids_pkg::CFG_SOURCE_WIDTH, w);
    cfg_write(ids_pkg::CFG_SOURCE_HEIGHT, h);
    cfg_write(ids_pkg::CFG_EMIT_ENABLE, {11'd0, emit});
  endtask

  task automatic add_pixels(input int n, input bit restart, input int noise);
    logic [7:0] v;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 7);
      v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      pix_q.push_back('{value: v,
                        start: (k == 0 && restart) || ($urandom_range(0, 999) < noise),
                        drain: 1'b0});
    end
  endtask

  // block idle: nothing queued, nothing in flight, pipeline flushed
  task automatic wait_idle();
    while (pix_q.size() != 0 || s_axis_tvalid || avg_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int w_rand;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // 28x28: one source pixel per sample point
    set_sizes(12'd28, 12'd28, 1'b1);
    for (int k = 0; k < 28; k++)
      pix_q.push_back('{value: (k % 2) ? 8'hFF : 8'h00, start: (k == 0), drain: 1'b0});
    for (int k = 0; k < 28; k++)
      pix_q.push_back('{value: (k < 14) ? 8'hFF : 8'h00, start: 1'b0, drain: 1'b0});

    // start of the third row; receiver holds off while pixels keep coming
    add_pixels(24, 1'b0, 0);
    while (pix_q.size() > 50) @(posedge clk);
    hold_asks++;
    wait_idle();

    // width register 0 clamps
    set_sizes(12'd0, 12'd57, 1'b1);
    add_pixels(30, 1'b1, 0);
    pix_q.push_back('{value: 8'd77, start: 1'b0, drain: 1'b1});
    add_pixels(15, 1'b0, 0);
    wait_idle();

    // counters keep running with output off
    cfg_write(ids_pkg::CFG_EMIT_ENABLE, 12'd0);
    add_pixels(12, 1'b0, 3);
    wait_idle();

    // width grows mid-frame
    cfg_write(ids_pkg::CFG_EMIT_ENABLE, 12'd1);
    cfg_write(ids_pkg::CFG_SOURCE_WIDTH, 12'd40);
    add_pixels(16, 1'b0, 4);
    wait_idle();

    // largest sizes, clamped width
    set_sizes(12'd1023, 12'd4095, 1'b1);
    add_pixels(15, 1'b1, 0);
    wait_idle();
    cfg_write(ids_pkg::CFG_SOURCE_WIDTH, 12'd512);
    add_pixels(8, 1'b0, 0);
    wait_idle();

    // odd ratio, height register 0 clamps
    w_rand = $urandom_range(29, 36);
    set_sizes(12'(w_rand), 12'd0, 1'b1);
    add_pixels(w_rand + 4, 1'b1, 2);

    while (pix_q.size() != 0 || s_axis_tvalid || avg_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && avg_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
